[rtl/h264_sps_header_parser_defines.svh]
// Assertion macros shared by the SPS header parser RTL.
`ifndef H264_SPS_HEADER_PARSER_DEFINES_SVH
`define H264_SPS_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SPS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/h264sps_pkg.sv]
// Shared types, codes and helpers of the H.264 SPS header parser.
`default_nettype none
package h264sps_pkg;

   localparam int unsigned MAX_ORDER_CYCLE_DEF  = 255;
   localparam int unsigned MAX_GOLOMB_ZEROS_DEF = 31;
   localparam int unsigned QUEUE_DEPTH_DEF      = 4;
   localparam int unsigned RSP_DATA_W           = 136;
   localparam int unsigned RSP_USER_W           = 4;

   typedef enum logic [4:0] {
      PH_PROFILE, PH_CONSTRAINT, PH_LEVEL, PH_ID, PH_CHROMA, PH_SEPARATE,
      PH_LUMA, PH_CDEPTH, PH_BYPASS, PH_MATRIX, PH_LISTFLAG, PH_DELTA,
      PH_LOG2FRAME, PH_POCTYPE, PH_LOG2POC, PH_ALWAYSZERO, PH_NONREF,
      PH_TOPBOTTOM, PH_CYCLELEN, PH_CYCLEOFS, PH_REFS, PH_GAPS, PH_WIDTH,
      PH_HEIGHT, PH_FRAMEONLY, PH_ADAPTIVE, PH_DIRECT, PH_CROPFLAG, PH_CROP,
      PH_VUI
   } phase_type;

   typedef enum logic [1:0] {K_BIT, K_BYTE, K_GOLOMB} kind_type;

   typedef enum logic [3:0] {
      ST_OK, ST_TRUNC, ST_RESERVED, ST_ID, ST_CHROMA, ST_DEPTH, ST_LOG2,
      ST_POCTYPE, ST_CYCLE, ST_OVERFLOW, ST_CROP, ST_GOLOMB
   } status_type;

   typedef enum logic [1:0] {DIM_IDLE, DIM_SUM, DIM_CHECK} dim_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   function automatic kind_type kind_of(input phase_type ph);
      kind_type k;
      unique case (ph)
         PH_PROFILE, PH_CONSTRAINT, PH_LEVEL: k = K_BYTE;
         PH_SEPARATE, PH_BYPASS, PH_MATRIX, PH_LISTFLAG, PH_ALWAYSZERO,
         PH_GAPS, PH_FRAMEONLY, PH_ADAPTIVE, PH_DIRECT, PH_CROPFLAG,
         PH_VUI: k = K_BIT;
         default: k = K_GOLOMB;
      endcase
      return k;
   endfunction

   function automatic logic is_extended(input logic [7:0] p);
      logic e;
      unique case (p)
         8'd44, 8'd83, 8'd86, 8'd100, 8'd110, 8'd118, 8'd122, 8'd128,
         8'd134, 8'd135, 8'd138, 8'd139, 8'd144, 8'd244: e = 1'b1;
         default: e = 1'b0;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

[rtl/h264sps_front.sv]
// Input side: accepts payload beats and queues them for the bit parser.
`default_nettype none
module h264sps_front
   import h264sps_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rbsp_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            beat_valid,
   output beat_type        beat,
   input  wire logic       beat_pop
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   beat_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_tready = (count_ff != CNT_FULL);
   assign beat_valid = (count_ff != '0);
   assign beat       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = beat_pop && beat_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{data: req_tdata, last: req_tlast};
      end
   end

endmodule
`default_nettype wire

[rtl/h264sps_parser.sv]
// Back side: bit-serial SPS syntax walker, size check and result register.
`default_nettype none
`include "h264_sps_header_parser_defines.svh"
module h264sps_parser
   import h264sps_pkg::*;
#(
   parameter int unsigned MAX_ORDER_CYCLE  = MAX_ORDER_CYCLE_DEF,
   parameter int unsigned MAX_GOLOMB_ZEROS = MAX_GOLOMB_ZEROS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  beat_valid,
   input  wire beat_type              beat,
   output logic                       beat_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   // byte feed
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic        have_ff, have_in;
   logic        last_ff, last_in;
   logic        end_pending_ff, end_pending_in;
   // field decoder
   phase_type   phase_ff, phase_in;
   logic [32:0] acc_ff, acc_in;
   logic [5:0]  zc_ff, zc_in;
   logic [5:0]  left_ff, left_in;
   logic        suffix_ff, suffix_in;
   logic [7:0]  loop_ff, loop_in;
   logic [7:0]  scale_last_ff, scale_last_in;
   logic [3:0]  list_ff, list_in;
   logic [6:0]  entry_ff, entry_in;
   logic        finished_ff, finished_in;
   // syntax values
   logic [31:0] wmb_ff, wmb_in;
   logic [31:0] hmb_ff, hmb_in;
   logic [31:0] crop_ff [4];
   logic [31:0] crop_in [4];
   logic        frame_only_ff, frame_only_in;
   logic        separate_ff, separate_in;
   logic        luma_bad_ff, luma_bad_in;
   logic [7:0]  profile_ff, profile_in;
   logic [7:0]  level_ff, level_in;
   logic [4:0]  set_id_ff, set_id_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic [3:0]  luma_depth_ff, luma_depth_in;
   logic [3:0]  chroma_depth_ff, chroma_depth_in;
   logic [1:0]  poc_ff, poc_in;
   logic [31:0] refs_ff, refs_in;
   logic [31:0] pic_w_ff, pic_w_in;
   logic [31:0] pic_h_ff, pic_h_in;
   logic        vui_ff, vui_in;
   // size unit
   dim_type     dim_ff, dim_in;
   logic [37:0] cw_ff, cw_in;
   logic [37:0] ch_ff, ch_in;
   logic [34:0] hc_ff, hc_in;
   logic [34:0] vc_ff, vc_in;
   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   // step temporaries
   logic        run;
   logic        bit_val;
   logic        done;
   logic        bad;
   logic [32:0] value;
   logic [32:0] acc_shift;
   logic [5:0]  zc_inc;
   logic        go_en;
   phase_type   go_ph;
   logic        dims;
   logic        emit;
   status_type  emit_status;
   logic        end_byte;
   logic        clear;
   logic [3:0]  list_inc;
   phase_type   next_list_ph;
   logic [7:0]  scale_new;
   logic [6:0]  entry_inc;
   logic [7:0]  loop_inc;
   logic [1:0]  cat;
   logic [32:0] hsum;
   logic [32:0] vsum;

   assign run = have_ff && !(rsp_valid_ff && !rsp_tready);
   assign bit_val = byte_ff[7];
   assign acc_shift = {acc_ff[31:0], bit_val};
   assign zc_inc = zc_ff + 1'b1;
   assign list_inc = list_ff + 1'b1;
   assign next_list_ph = (list_inc < ((chroma_ff == 2'd3) ? 4'd12 : 4'd8)) ?
                         PH_LISTFLAG : PH_LOG2FRAME;
   assign entry_inc = entry_ff + 1'b1;
   assign loop_inc = loop_ff + 1'b1;
   assign cat = separate_ff ? 2'd0 : chroma_ff;
   assign hsum = {1'b0, crop_ff[0]} + {1'b0, crop_ff[1]};
   assign vsum = {1'b0, crop_ff[2]} + {1'b0, crop_ff[3]};
   // odd codes add (v+1)/2, even codes subtract v/2, all modulo 256
   assign scale_new = value[0] ? (scale_last_ff + value[8:1] + 8'd1)
                               : (scale_last_ff - value[8:1]);

   // one bit of the current field
   always_comb begin : feed
      done    = 1'b0;
      bad     = 1'b0;
      value   = '0;
      unique case (kind_of(phase_ff))
         K_BIT: begin
            done  = 1'b1;
            value = {32'd0, bit_val};
         end
         K_BYTE: begin
            value = {25'd0, acc_ff[6:0], bit_val};
            done  = (left_ff == 6'd1);
         end
         default: begin
            if (!suffix_ff) begin
               if (!bit_val) begin
                  bad = (zc_inc > 6'(MAX_GOLOMB_ZEROS));
               end else if (zc_ff == '0) begin
                  done = 1'b1;
               end
            end else if (left_ff == 6'd1) begin
               value = acc_shift - 33'd1;
               bad   = value[32];
               done  = !value[32];
            end
         end
      endcase
   end

   always_comb begin : next_state
      byte_in         = byte_ff;
      bit_cnt_in      = bit_cnt_ff;
      have_in         = have_ff;
      last_in         = last_ff;
      end_pending_in  = end_pending_ff;
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      zc_in           = zc_ff;
      left_in         = left_ff;
      suffix_in       = suffix_ff;
      loop_in         = loop_ff;
      scale_last_in   = scale_last_ff;
      list_in         = list_ff;
      entry_in        = entry_ff;
      finished_in     = finished_ff;
      wmb_in          = wmb_ff;
      hmb_in          = hmb_ff;
      crop_in         = crop_ff;
      frame_only_in   = frame_only_ff;
      separate_in     = separate_ff;
      luma_bad_in     = luma_bad_ff;
      profile_in      = profile_ff;
      level_in        = level_ff;
      set_id_in       = set_id_ff;
      chroma_in       = chroma_ff;
      luma_depth_in   = luma_depth_ff;
      chroma_depth_in = chroma_depth_ff;
      poc_in          = poc_ff;
      refs_in         = refs_ff;
      pic_w_in        = pic_w_ff;
      pic_h_in        = pic_h_ff;
      vui_in          = vui_ff;
      dim_in          = dim_ff;
      cw_in           = cw_ff;
      ch_in           = ch_ff;
      hc_in           = hc_ff;
      vc_in           = vc_ff;
      beat_pop        = 1'b0;
      go_en           = 1'b0;
      go_ph           = phase_ff;
      dims            = 1'b0;
      emit            = 1'b0;
      emit_status     = ST_OK;
      end_byte        = 1'b0;
      clear           = 1'b0;

      if (!have_ff) begin
         if (beat_valid) begin
            beat_pop   = 1'b1;
            have_in    = 1'b1;
            byte_in    = beat.data;
            last_in    = beat.last;
            bit_cnt_in = '0;
         end
      end else if (run) begin
         unique case (dim_ff)
            DIM_SUM: begin
               cw_in  = {1'b0, {1'b0, wmb_ff} + 33'd1, 4'd0};
               ch_in  = frame_only_ff ? {1'b0, {1'b0, hmb_ff} + 33'd1, 4'd0}
                                      : {{1'b0, hmb_ff} + 33'd1, 5'd0};
               hc_in  = ((cat == 2'd1) || (cat == 2'd2)) ? {1'b0, hsum, 1'b0}
                                                          : {2'd0, hsum};
               priority case ({cat == 2'd1, frame_only_ff})
                  2'b11, 2'b00: vc_in = {1'b0, vsum, 1'b0};
                  2'b10:        vc_in = {vsum, 2'd0};
                  default:      vc_in = {2'd0, vsum};
               endcase
               dim_in = DIM_CHECK;
            end
            DIM_CHECK: begin
               dim_in = DIM_IDLE;
               if (cw_ff[37:32] != '0 || ch_ff[37:32] != '0) begin
                  emit        = 1'b1;
                  emit_status = ST_OVERFLOW;
               end else if ({3'd0, hc_ff} >= cw_ff || {3'd0, vc_ff} >= ch_ff) begin
                  emit        = 1'b1;
                  emit_status = ST_CROP;
               end else begin
                  pic_w_in = cw_ff[31:0] - hc_ff[31:0];
                  pic_h_in = ch_ff[31:0] - vc_ff[31:0];
                  go_en    = 1'b1;
                  go_ph    = PH_VUI;
               end
               end_byte       = end_pending_ff;
               end_pending_in = 1'b0;
            end
            default: begin
               if (finished_ff) begin
                  // drop the rest of the beat once the result is out
                  end_byte = 1'b1;
               end else begin
                  byte_in    = {byte_ff[6:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  unique case (kind_of(phase_ff))
                     K_BIT: ;
                     K_BYTE: begin
                        acc_in  = {25'd0, acc_ff[6:0], bit_val};
                        left_in = left_ff - 1'b1;
                     end
                     default: begin
                        if (!suffix_ff) begin
                           if (!bit_val) begin
                              zc_in = zc_inc;
                           end else if (zc_ff != '0) begin
                              suffix_in = 1'b1;
                              left_in   = zc_ff;
                              acc_in    = 33'd1;
                           end
                        end else begin
                           acc_in  = acc_shift;
                           left_in = left_ff - 1'b1;
                        end
                     end
                  endcase
                  if (bad) begin
                     emit        = 1'b1;
                     emit_status = ST_GOLOMB;
                  end else if (done) begin
                     unique case (phase_ff)
                        PH_PROFILE: begin
                           profile_in = value[7:0];
                           go_en = 1'b1; go_ph = PH_CONSTRAINT;
                        end
                        PH_CONSTRAINT: begin
                           if (value[1:0] != 2'd0) begin
                              emit = 1'b1; emit_status = ST_RESERVED;
                           end else begin
                              go_en = 1'b1; go_ph = PH_LEVEL;
                           end
                        end
                        PH_LEVEL: begin
                           level_in = value[7:0];
                           go_en = 1'b1; go_ph = PH_ID;
                        end
                        PH_ID: begin
                           if (value > 33'd31) begin
                              emit = 1'b1; emit_status = ST_ID;
                           end else begin
                              set_id_in = value[4:0];
                              go_en = 1'b1;
                              go_ph = is_extended(profile_ff) ? PH_CHROMA : PH_LOG2FRAME;
                           end
                        end
                        PH_CHROMA: begin
                           if (value > 33'd3) begin
                              emit = 1'b1; emit_status = ST_CHROMA;
                           end else begin
                              chroma_in = value[1:0];
                              go_en = 1'b1;
                              go_ph = (value[1:0] == 2'd3) ? PH_SEPARATE : PH_LUMA;
                           end
                        end
                        PH_SEPARATE: begin
                           if (value[0]) separate_in = 1'b1;
                           go_en = 1'b1; go_ph = PH_LUMA;
                        end
                        PH_LUMA: begin
                           if (value > 33'd6) luma_bad_in = 1'b1;
                           else loop_in = value[7:0];
                           go_en = 1'b1; go_ph = PH_CDEPTH;
                        end
                        PH_CDEPTH: begin
                           if (luma_bad_ff || value > 33'd6) begin
                              emit = 1'b1; emit_status = ST_DEPTH;
                           end else begin
                              luma_depth_in   = 4'd8 + loop_ff[3:0];
                              chroma_depth_in = 4'd8 + value[3:0];
                              go_en = 1'b1; go_ph = PH_BYPASS;
                           end
                        end
                        PH_BYPASS: begin
                           go_en = 1'b1; go_ph = PH_MATRIX;
                        end
                        PH_MATRIX: begin
                           list_in = '0;
                           go_en = 1'b1;
                           go_ph = value[0] ? PH_LISTFLAG : PH_LOG2FRAME;
                        end
                        PH_LISTFLAG: begin
                           go_en = 1'b1;
                           if (value[0]) begin
                              entry_in      = '0;
                              scale_last_in = 8'd8;
                              go_ph         = PH_DELTA;
                           end else begin
                              list_in = list_inc;
                              go_ph   = next_list_ph;
                           end
                        end
                        PH_DELTA: begin
                           if (scale_new != '0) scale_last_in = scale_new;
                           entry_in = entry_inc;
                           go_en    = 1'b1;
                           if (scale_new == '0 ||
                               entry_inc >= ((list_ff < 4'd6) ? 7'd16 : 7'd64)) begin
                              list_in = list_inc;
                              go_ph   = next_list_ph;
                           end else begin
                              go_ph = PH_DELTA;
                           end
                        end
                        PH_LOG2FRAME: begin
                           if (value > 33'd12) begin
                              emit = 1'b1; emit_status = ST_LOG2;
                           end else begin
                              go_en = 1'b1; go_ph = PH_POCTYPE;
                           end
                        end
                        PH_POCTYPE: begin
                           if (value > 33'd2) begin
                              emit = 1'b1; emit_status = ST_POCTYPE;
                           end else begin
                              poc_in = value[1:0];
                              go_en  = 1'b1;
                              priority case (value[1:0])
                                 2'd0:    go_ph = PH_LOG2POC;
                                 2'd2:    go_ph = PH_REFS;
                                 default: go_ph = PH_ALWAYSZERO;
                              endcase
                           end
                        end
                        PH_LOG2POC: begin
                           if (value > 33'd12) begin
                              emit = 1'b1; emit_status = ST_LOG2;
                           end else begin
                              go_en = 1'b1; go_ph = PH_REFS;
                           end
                        end
                        PH_ALWAYSZERO: begin
                           go_en = 1'b1; go_ph = PH_NONREF;
                        end
                        PH_NONREF: begin
                           go_en = 1'b1; go_ph = PH_TOPBOTTOM;
                        end
                        PH_TOPBOTTOM: begin
                           go_en = 1'b1; go_ph = PH_CYCLELEN;
                        end
                        PH_CYCLELEN: begin
                           if (value > 33'(MAX_ORDER_CYCLE)) begin
                              emit = 1'b1; emit_status = ST_CYCLE;
                           end else begin
                              loop_in = value[7:0];
                              go_en   = 1'b1;
                              go_ph   = (value[7:0] == '0) ? PH_REFS : PH_CYCLEOFS;
                           end
                        end
                        PH_CYCLEOFS: begin
                           loop_in = loop_ff - 1'b1;
                           go_en   = 1'b1;
                           go_ph   = (loop_ff == 8'd1) ? PH_REFS : PH_CYCLEOFS;
                        end
                        PH_REFS: begin
                           refs_in = value[31:0];
                           go_en = 1'b1; go_ph = PH_GAPS;
                        end
                        PH_GAPS: begin
                           go_en = 1'b1; go_ph = PH_WIDTH;
                        end
                        PH_WIDTH: begin
                           wmb_in = value[31:0];
                           go_en = 1'b1; go_ph = PH_HEIGHT;
                        end
                        PH_HEIGHT: begin
                           hmb_in = value[31:0];
                           go_en = 1'b1; go_ph = PH_FRAMEONLY;
                        end
                        PH_FRAMEONLY: begin
                           frame_only_in = value[0];
                           go_en = 1'b1;
                           go_ph = value[0] ? PH_DIRECT : PH_ADAPTIVE;
                        end
                        PH_ADAPTIVE: begin
                           go_en = 1'b1; go_ph = PH_DIRECT;
                        end
                        PH_DIRECT: begin
                           go_en = 1'b1; go_ph = PH_CROPFLAG;
                        end
                        PH_CROPFLAG: begin
                           if (!value[0]) begin
                              dims = 1'b1;
                           end else begin
                              loop_in = '0;
                              go_en = 1'b1; go_ph = PH_CROP;
                           end
                        end
                        PH_CROP: begin
                           crop_in[loop_ff[1:0]] = value[31:0];
                           loop_in = loop_inc;
                           if (loop_inc >= 8'd4) begin
                              dims = 1'b1;
                           end else begin
                              go_en = 1'b1; go_ph = PH_CROP;
                           end
                        end
                        PH_VUI: begin
                           vui_in = value[0];
                           emit = 1'b1; emit_status = ST_OK;
                        end
                        default: begin
                           emit = 1'b1; emit_status = ST_TRUNC;
                        end
                     endcase
                  end
                  if (dims) begin
                     // hold the beat until the size check has run
                     dim_in         = DIM_SUM;
                     end_pending_in = (bit_cnt_ff == 3'd7);
                  end else begin
                     end_byte = (bit_cnt_ff == 3'd7);
                  end
               end
            end
         endcase

         if (go_en) begin
            phase_in  = go_ph;
            acc_in    = '0;
            zc_in     = '0;
            suffix_in = 1'b0;
            left_in   = (kind_of(go_ph) == K_BYTE) ? 6'd8 : 6'd0;
         end
         if (end_byte) begin
            have_in = 1'b0;
            if (last_ff) begin
               clear = 1'b1;
               if (!finished_ff && !emit) begin
                  emit        = 1'b1;
                  emit_status = ST_TRUNC;
               end
            end
         end
         if (emit) finished_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_ff         <= 1'b0;
         bit_cnt_ff      <= '0;
         end_pending_ff  <= 1'b0;
         phase_ff        <= PH_PROFILE;
         acc_ff          <= '0;
         zc_ff           <= '0;
         left_ff         <= 6'd8;
         suffix_ff       <= 1'b0;
         loop_ff         <= '0;
         scale_last_ff   <= 8'd8;
         list_ff         <= '0;
         entry_ff        <= '0;
         finished_ff     <= 1'b0;
         wmb_ff          <= '0;
         hmb_ff          <= '0;
         for (int i = 0; i < 4; i++) crop_ff[i] <= '0;
         frame_only_ff   <= 1'b1;
         separate_ff     <= 1'b0;
         luma_bad_ff     <= 1'b0;
         profile_ff      <= '0;
         level_ff        <= '0;
         set_id_ff       <= '0;
         chroma_ff       <= 2'd1;
         luma_depth_ff   <= 4'd8;
         chroma_depth_ff <= 4'd8;
         poc_ff          <= '0;
         refs_ff         <= '0;
         pic_w_ff        <= '0;
         pic_h_ff        <= '0;
         vui_ff          <= 1'b0;
         dim_ff          <= DIM_IDLE;
      end else begin
         have_ff         <= have_in;
         bit_cnt_ff      <= bit_cnt_in;
         end_pending_ff  <= end_pending_in;
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         zc_ff           <= zc_in;
         left_ff         <= left_in;
         suffix_ff       <= suffix_in;
         loop_ff         <= loop_in;
         scale_last_ff   <= scale_last_in;
         list_ff         <= list_in;
         entry_ff        <= entry_in;
         finished_ff     <= finished_in;
         wmb_ff          <= wmb_in;
         hmb_ff          <= hmb_in;
         crop_ff         <= crop_in;
         frame_only_ff   <= frame_only_in;
         separate_ff     <= separate_in;
         luma_bad_ff     <= luma_bad_in;
         profile_ff      <= profile_in;
         level_ff        <= level_in;
         set_id_ff       <= set_id_in;
         chroma_ff       <= chroma_in;
         luma_depth_ff   <= luma_depth_in;
         chroma_depth_ff <= chroma_depth_in;
         poc_ff          <= poc_in;
         refs_ff         <= refs_in;
         pic_w_ff        <= pic_w_in;
         pic_h_ff        <= pic_h_in;
         vui_ff          <= vui_in;
         dim_ff          <= dim_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_in_reg: begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         cw_ff   <= cw_in;
         ch_ff   <= ch_in;
         hc_ff   <= hc_in;
         vc_ff   <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_user_ff <= emit_status;
         rsp_data_ff <= {6'd0, vui_in,
                         (emit_status == ST_OK) ? pic_h_in : 32'd0,
                         (emit_status == ST_OK) ? pic_w_in : 32'd0,
                         refs_in, poc_in, chroma_depth_in, luma_depth_in,
                         chroma_in, set_id_in, level_in, profile_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `SPS_ASSERT_HOLDS(a_single_result, emit, !finished_ff,
      "second result for one parameter set")
   `SPS_ASSERT_HOLDS(a_dim_phase, dim_ff != DIM_IDLE,
      phase_ff == PH_CROPFLAG || phase_ff == PH_CROP, "size check outside crop fields")
   `SPS_ASSERT_HOLDS(a_list_range, phase_ff == PH_DELTA,
      entry_ff < 7'd64 && list_ff < 4'd12, "scaling list index out of range")
   `SPS_ASSERT_NEXT(a_restart, clear,
      phase_ff == PH_PROFILE && !finished_ff && !have_ff, "parser not restarted after last beat")

endmodule
`default_nettype wire

[rtl/h264_sps_header_parser.sv]
// The bit parser takes one bit per cycle, except while a result waits on rsp_tready.
// Each beat is loaded before its bits, and the size check runs DIM_SUM, then DIM_CHECK.
// A result is registered in the cycle after the bit (or beat end) that decides it.
// Beats after a result are loaded and dropped whole until the last beat.
// The single bit-serial field decoder sets the rate; a new beat loads only once the last is used up.
// Reset is synchronous and active high; the parser also restarts after each last beat.
`default_nettype none
module h264_sps_header_parser
   import h264sps_pkg::*;
#(
   parameter int unsigned MAX_ORDER_CYCLE  = MAX_ORDER_CYCLE_DEF,
   parameter int unsigned MAX_GOLOMB_ZEROS = MAX_GOLOMB_ZEROS_DEF,
   parameter int unsigned QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] rbsp_byte
   input  wire logic                  req_tlast,  // last_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] profile, [15:8] level, [20:16] set_id, [22:21] chroma_format,
   // [26:23] luma_depth, [30:27] chroma_depth, [32:31] order_count_type,
   // [64:33] reference_frames, [96:65] picture_width,
   // [128:97] picture_height, [129] vui_present, [135:130] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser   // [3:0] status
);

   logic     beat_valid;
   beat_type beat;
   logic     beat_pop;

   h264sps_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_pop   (beat_pop)
   );

   h264sps_parser #(
      .MAX_ORDER_CYCLE  (MAX_ORDER_CYCLE),
      .MAX_GOLOMB_ZEROS (MAX_GOLOMB_ZEROS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_pop   (beat_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
